// ----- sv/axrot_pkg.sv -----
`default_nettype none

package axrot_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int TRIG_ITERATIONS = 16;
  localparam int AngleWidth      = 32;
  localparam int InWidth         = 6 * COORD_WIDTH + AngleWidth;
  localparam int OutWidth        = 3 * COORD_WIDTH;
  localparam int OutUserWidth    = 2;

  // angles in Q16.16 degrees
  localparam logic [32:0] Deg360    = 33'd23592960;
  localparam logic [24:0] Deg90     = 25'd5898240;
  localparam logic [24:0] Deg180    = 25'd11796480;
  localparam logic [24:0] Deg270    = 25'd17694720;
  // 92 turns: lifts any 32-bit angle to a nonnegative value
  localparam logic [32:0] AngOffset = 33'd2170552320;
  // round(pi/180 * 2^40)
  localparam logic [34:0] RadConst  = 35'd19190098069;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [39:0] OneQ30     = 40'sd1073741824;
  localparam logic signed [39:0] CoordMax   = 40'sd2147483647;
  localparam logic signed [39:0] CoordMin   = -40'sd2147483648;

  typedef struct packed {
    logic        neg;
    logic [66:0] mag;
  } prod_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd843314857;
      5'd1:    r = 30'd497837829;
      5'd2:    r = 30'd263043837;
      5'd3:    r = 30'd133525159;
      5'd4:    r = 30'd67021687;
      5'd5:    r = 30'd33543516;
      5'd6:    r = 30'd16775851;
      5'd7:    r = 30'd8388437;
      5'd8:    r = 30'd4194283;
      5'd9:    r = 30'd2097149;
      5'd31:   r = 30'd0;
      default: r = 30'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

  // sign-magnitude product, a up to 35 magnitude bits, b up to 32
  function automatic prod_t mul_sm(input logic signed [39:0] a,
                                   input logic signed [39:0] b);
    prod_t       r;
    logic [39:0] ma;
    logic [39:0] mb;
    ma = a[39] ? 40'(-a) : 40'(a);
    mb = b[39] ? 40'(-b) : 40'(b);
    r.neg = a[39] ^ b[39];
    r.mag = 67'(ma[34:0]) * 67'(mb[31:0]);
    return r;
  endfunction

  // Q16.16 x Q2.30 product back to Q16.16, half up on the magnitude
  function automatic logic signed [39:0] rnd_q30(input prod_t p);
    logic [66:0]        sum;
    logic signed [39:0] m;
    sum = p.mag + 67'd536870912;
    m   = $signed({3'b000, sum[66:30]});
    return p.neg ? -m : m;
  endfunction

endpackage

`default_nettype wire

// ----- sv/axis_angle_vector_rotation.sv -----
`default_nettype none

// Rotates a Q16.16 vector about an arbitrary Q16.16 axis by an angle in degrees
// (Rodrigues' formula, right-hand rule). Fully pipelined: one transaction is
// accepted per cycle unless the output stalls; the pipeline depth is set by
// the bit-serial square root (31 stages) and divider (31 stages) that
// normalize the axis, and one stage per CORDIC iteration.
// A stalled output holds the whole pipeline. tuser flags a zero-length axis
// (vector passed through) and saturation of any output component.
module axis_angle_vector_rotation #(
  parameter int TRIG_ITERATIONS = axrot_pkg::TRIG_ITERATIONS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg
  input  wire logic [axrot_pkg::InWidth-1:0]      s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // out_x, out_y, out_z
  output logic [axrot_pkg::OutWidth-1:0]          m_axis_tdata,
  // axis_zero, overflow
  output logic [axrot_pkg::OutUserWidth-1:0]      m_axis_tuser
);
  import axrot_pkg::*;

  localparam int StMag   = 1;
  localparam int StLz    = 2;
  localparam int StShift = 3;
  localparam int StSq    = 4;
  localparam int StSum   = 5;
  localparam int StSqrt  = 6;
  localparam int StDiv   = StSqrt + 31;
  localparam int StK     = StDiv + 31;
  localparam int StMod   = StK + 1;
  localparam int StFold  = StMod + 8;
  localparam int StRmul  = StFold + 1;
  localparam int StRad   = StRmul + 1;
  localparam int StCord  = StRad + 1;
  localparam int StFlip  = StCord + TRIG_ITERATIONS;
  localparam int StR1    = StFlip + 1;
  localparam int StOut   = StR1 + 8;
  localparam int NumStages = StOut + 1;

  typedef struct packed {
    logic [2:0][31:0]   vec;
    logic [2:0][31:0]   ax;
    logic [31:0]        angle;
    logic [2:0]         aneg;
    logic [2:0][31:0]   mag;
    logic [31:0]        mmax;
    logic               azero;
    logic               shr;
    logic [4:0]         sh;
    logic [2:0][59:0]   sq;
    logic [62:0]        srem;
    logic [30:0]        root;
    logic [2:0][60:0]   drem;
    logic [2:0][30:0]   quo;
    logic [2:0][31:0]   k;
    logic [32:0]        ang;
    logic               flip;
    logic               rneg;
    logic [22:0]        rmag;
    logic [57:0]        rprod;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
    prod_t [2:0][2:0]   pvk;
    prod_t [2:0]        pc;
    logic [2:0][2:0][39:0] rvk;
    logic [2:0][39:0]   rc;
    logic signed [39:0] dot;
    logic signed [39:0] omc;
    logic [2:0][39:0]   cr;
    prod_t              pt;
    prod_t [2:0]        pcr;
    logic signed [39:0] t;
    logic [2:0][39:0]   crs;
    prod_t [2:0]        ptk;
    logic [2:0][39:0]   tk;
    logic [2:0][39:0]   sum;
    logic [2:0][31:0]   res;
    logic               ovf;
  } item_t;

  function automatic item_t step(input item_t a, input int s);
    item_t              r;
    logic [31:0]        x;
    logic [4:0]         p;
    logic [62:0]        t63;
    logic [60:0]        dv;
    logic [60:0]        dlen;
    logic [32:0]        dm;
    logic [24:0]        rm;
    logic signed [25:0] rr;
    logic [31:0]        q;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    logic signed [39:0] sv;
    int                 b;
    r = a;
    if (s == StMag) begin
      for (int i = 0; i < 3; i++) begin
        r.aneg[i] = a.ax[i][31];
        r.mag[i]  = a.ax[i][31] ? 32'(-a.ax[i]) : a.ax[i];
      end
      x = (r.mag[0] > r.mag[1]) ? r.mag[0] : r.mag[1];
      r.mmax  = (r.mag[2] > x) ? r.mag[2] : x;
      r.azero = (r.mmax == 32'd0);
      r.ang   = {a.angle[31], a.angle} + AngOffset;
    end else if (s == StLz) begin
      x = a.mmax;
      p = '0;
      if (x[31:16] != 16'd0) begin p[4] = 1'b1; x = x >> 16; end
      if (x[15:8] != 8'd0) begin p[3] = 1'b1; x = x >> 8; end
      if (x[7:4] != 4'd0) begin p[2] = 1'b1; x = x >> 4; end
      if (x[3:2] != 2'd0) begin p[1] = 1'b1; x = x >> 2; end
      if (x[1]) begin p[0] = 1'b1; end
      r.shr = (p >= 5'd30);
      r.sh  = r.shr ? 5'(p - 5'd29) : 5'(5'd29 - p);
    end else if (s == StShift) begin
      for (int i = 0; i < 3; i++) begin
        r.mag[i] = a.shr ? (a.mag[i] >> a.sh) : (a.mag[i] << a.sh);
      end
    end else if (s == StSq) begin
      for (int i = 0; i < 3; i++) begin
        r.sq[i] = 60'(a.mag[i][29:0]) * 60'(a.mag[i][29:0]);
      end
    end else if (s == StSum) begin
      r.srem = {3'b000, a.sq[0]} + {3'b000, a.sq[1]} + {3'b000, a.sq[2]};
      r.root = '0;
    end else if (s >= StSqrt && s < StDiv) begin
      b   = 30 - (s - StSqrt);
      t63 = ({32'b0, a.root} << (b + 1)) | (63'd1 << (2 * b));
      if (a.srem >= t63) begin
        r.srem    = a.srem - t63;
        r.root[b] = 1'b1;
      end
    end else if (s >= StDiv && s < StK) begin
      b    = 30 - (s - StDiv);
      dlen = {30'b0, a.root} << b;
      for (int i = 0; i < 3; i++) begin
        dv = (b == 30) ? {1'b0, a.mag[i][29:0], 30'b0} : a.drem[i];
        if (b == 30) begin
          r.quo[i] = '0;
        end
        if (dv >= dlen) begin
          dv          = dv - dlen;
          r.quo[i][b] = 1'b1;
        end
        r.drem[i] = dv;
      end
    end else if (s == StK) begin
      for (int i = 0; i < 3; i++) begin
        r.k[i] = a.aneg[i] ? 32'(-{1'b0, a.quo[i]}) : {1'b0, a.quo[i]};
      end
    end else if (s >= StMod && s < StFold) begin
      b  = 7 - (s - StMod);
      dm = Deg360 << b;
      if (a.ang >= dm) begin
        r.ang = a.ang - dm;
      end
    end else if (s == StFold) begin
      rm = a.ang[24:0];
      if (rm <= Deg90) begin
        rr     = $signed({1'b0, rm});
        r.flip = 1'b0;
      end else if (rm < Deg270) begin
        rr     = $signed({1'b0, rm}) - $signed({1'b0, Deg180});
        r.flip = 1'b1;
      end else begin
        rr     = $signed({1'b0, rm}) - $signed({1'b0, Deg360[24:0]});
        r.flip = 1'b0;
      end
      r.rneg = rr[25];
      r.rmag = rr[25] ? 23'(-rr) : 23'(rr);
    end else if (s == StRmul) begin
      r.rprod = 58'(a.rmag) * 58'(RadConst);
    end else if (s == StRad) begin
      q    = 32'((a.rprod + (58'd1 << 25)) >> 26);
      r.cz = a.rneg ? -$signed({2'b00, q}) : $signed({2'b00, q});
      r.cx = CordicGain;
      r.cy = '0;
    end else if (s >= StCord && s < StFlip) begin
      b  = s - StCord;
      dx = a.cy >>> b;
      dy = a.cx >>> b;
      at = $signed({4'b0000, atan_q30(5'(b))});
      if (a.cz >= 0) begin
        r.cx = a.cx - dx;
        r.cy = a.cy + dy;
        r.cz = a.cz - at;
      end else begin
        r.cx = a.cx + dx;
        r.cy = a.cy - dy;
        r.cz = a.cz + at;
      end
    end else if (s == StFlip) begin
      if (a.flip) begin
        r.cx = -a.cx;
        r.cy = -a.cy;
      end
    end else if (s == StR1) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          r.pvk[i][j] = mul_sm(40'($signed(a.vec[i])), 40'($signed(a.k[j])));
        end
        r.pc[i] = mul_sm(40'($signed(a.vec[i])), 40'(a.cx));
      end
    end else if (s == StR1 + 1) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          r.rvk[i][j] = rnd_q30(a.pvk[i][j]);
        end
        r.rc[i] = rnd_q30(a.pc[i]);
      end
    end else if (s == StR1 + 2) begin
      r.dot   = $signed(a.rvk[0][0]) + $signed(a.rvk[1][1]) + $signed(a.rvk[2][2]);
      r.cr[0] = $signed(a.rvk[2][1]) - $signed(a.rvk[1][2]);
      r.cr[1] = $signed(a.rvk[0][2]) - $signed(a.rvk[2][0]);
      r.cr[2] = $signed(a.rvk[1][0]) - $signed(a.rvk[0][1]);
      r.omc   = OneQ30 - 40'(a.cx);
    end else if (s == StR1 + 3) begin
      r.pt = mul_sm(a.dot, a.omc);
      for (int i = 0; i < 3; i++) begin
        r.pcr[i] = mul_sm($signed(a.cr[i]), 40'(a.cy));
      end
    end else if (s == StR1 + 4) begin
      r.t = rnd_q30(a.pt);
      for (int i = 0; i < 3; i++) begin
        r.crs[i] = rnd_q30(a.pcr[i]);
      end
    end else if (s == StR1 + 5) begin
      for (int i = 0; i < 3; i++) begin
        r.ptk[i] = mul_sm(a.t, 40'($signed(a.k[i])));
      end
    end else if (s == StR1 + 6) begin
      for (int i = 0; i < 3; i++) begin
        r.tk[i] = rnd_q30(a.ptk[i]);
      end
    end else if (s == StR1 + 7) begin
      for (int i = 0; i < 3; i++) begin
        r.sum[i] = $signed(a.rc[i]) + $signed(a.tk[i]) + $signed(a.crs[i]);
      end
    end else if (s == StOut) begin
      r.ovf = 1'b0;
      for (int i = 0; i < 3; i++) begin
        sv = $signed(a.sum[i]);
        if (a.azero) begin
          r.res[i] = a.vec[i];
        end else if (sv > CoordMax) begin
          r.res[i] = CoordMax[31:0];
          r.ovf    = 1'b1;
        end else if (sv < CoordMin) begin
          r.res[i] = CoordMin[31:0];
          r.ovf    = 1'b1;
        end else begin
          r.res[i] = sv[31:0];
        end
      end
      if (a.azero) begin
        r.ovf = 1'b0;
      end
    end
    return r;
  endfunction

  item_t                pipe_q [NumStages];
  item_t                pipe_d [NumStages];
  logic [NumStages-1:0] vld_q;
  logic                 adv;

  assign adv           = !vld_q[NumStages-1] || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    pipe_d[0] = '0;
    for (int i = 0; i < 3; i++) begin
      pipe_d[0].vec[i] = s_axis_tdata[32*i +: 32];
      pipe_d[0].ax[i]  = s_axis_tdata[96 + 32*i +: 32];
    end
    pipe_d[0].angle = s_axis_tdata[InWidth-1 -: AngleWidth];
  end

  for (genvar s = 1; s < NumStages; s++) begin : g_stage
    always_comb begin
      pipe_d[s] = step(pipe_q[s-1], s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < NumStages; s++) begin
        pipe_q[s] <= pipe_d[s];
      end
    end
  end

  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = {pipe_q[NumStages-1].res[2], pipe_q[NumStages-1].res[1],
                          pipe_q[NumStages-1].res[0]};
  assign m_axis_tuser  = {pipe_q[NumStages-1].ovf, pipe_q[NumStages-1].azero};

endmodule

`default_nettype wire
